[sv/assert_macros.svh]
// Assertion macros for the span rasterizer RTL; fcsr_back is their only user.
// Depends on nothing; defining SYNTH leaves every macro empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define FCSR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

`define FCSR_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define FCSR_ASSERT(label, clk, rst, prop)

`define FCSR_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

[sv/fcsr_pkg.sv]
// Types, constants and widths for the filled circle span rasterizer.
// Depends on nothing; every other RTL module imports it.
`default_nettype none

package fcsr_pkg;

  localparam int COORD_BITS  = 10;
  localparam int RADIUS_BITS = 9;
  localparam int COLOR_BITS  = 16;
  localparam int CLIP_BITS   = 11;

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  // Signed working width for span coordinates, which may fall off either edge.
  localparam int SPAN_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 3;
  // Signed width of the midpoint decision value.
  localparam int DEC_W = RADIUS_BITS + 3;
  // Offset within a span stays below twice the radius.
  localparam int POS_W = RADIUS_BITS + 1;

  localparam int DEC_STEP_IN  = 3;
  localparam int DEC_STEP_OUT = 5;

  localparam logic [CLIP_BITS-1:0] CLIP_WIDTH_RESET  = CLIP_BITS'(320);
  localparam logic [CLIP_BITS-1:0] CLIP_HEIGHT_RESET = CLIP_BITS'(240);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 1'b1;

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // Spans of one pass, in drawing order.
  localparam logic [1:0] SPAN_NARROW_BOT = 2'd0;
  localparam logic [1:0] SPAN_WIDE_BOT   = 2'd1;
  localparam logic [1:0] SPAN_NARROW_TOP = 2'd2;
  localparam logic [1:0] SPAN_WIDE_TOP   = 2'd3;

  typedef struct packed {
    logic                   mode;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius;
    logic [COLOR_BITS-1:0]  fill_color;
  } fcsr_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  write_valid;
    logic                  done_res;
  } fcsr_result_t;

  typedef struct packed {
    logic                   start;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius;
    logic [COLOR_BITS-1:0]  fill_color;
  } fcsr_cmd_t;

  typedef struct packed {
    logic [CLIP_BITS-1:0] width;
    logic [CLIP_BITS-1:0] height;
  } fcsr_clip_t;

endpackage

`default_nettype wire

[sv/fcsr_cfg.sv]
// Clip window registers of the span rasterizer, written through a plain write port.
// Depends on fcsr_pkg.
`default_nettype none

module fcsr_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [fcsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcsr_pkg::CLIP_BITS-1:0]   cfg_wdata,
  output fcsr_pkg::fcsr_clip_t             clip
);
  import fcsr_pkg::*;

  fcsr_clip_t clip_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_reg.width  <= CLIP_WIDTH_RESET;
      clip_reg.height <= CLIP_HEIGHT_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_CLIP_WIDTH:  clip_reg.width  <= cfg_wdata;
        CFG_CLIP_HEIGHT: clip_reg.height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign clip = clip_reg;

endmodule

`default_nettype wire

[sv/fcsr_front.sv]
// Front end: takes requests, classifies them as start or advance and queues them.
// Depends on fcsr_pkg.
`default_nettype none

module fcsr_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  fcsr_pkg::fcsr_item_t  item,
  output logic                  cmd_valid,
  input  logic                  cmd_take,
  output fcsr_pkg::fcsr_cmd_t   cmd
);
  import fcsr_pkg::*;

  fcsr_cmd_t           slot [QDEPTH];
  fcsr_cmd_t           decoded;
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  always_comb begin
    decoded.start      = (item.mode == MODE_START);
    decoded.center_x   = item.center_x;
    decoded.center_y   = item.center_y;
    decoded.radius     = item.radius;
    decoded.fill_color = item.fill_color;
  end

  assign full      = (count == QCNT_W'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;
  assign cmd       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/fcsr_back.sv]
// Back end: midpoint circle span walker producing one pixel request per command,
// followed by the result queue. Depends on fcsr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fcsr_back (
  input  logic                   clk,
  input  logic                   rst,
  input  fcsr_pkg::fcsr_clip_t   clip,
  input  logic                   cmd_valid,
  output logic                   cmd_take,
  input  fcsr_pkg::fcsr_cmd_t    cmd,
  output logic                   empty,
  input  logic                   pop,
  output fcsr_pkg::fcsr_result_t result
);
  import fcsr_pkg::*;

  logic                          busy;
  logic                          busy_next;
  logic [COORD_BITS-1:0]         centre_col;
  logic [COORD_BITS-1:0]         centre_row;
  logic [RADIUS_BITS-1:0]        radius_r;
  logic [RADIUS_BITS-1:0]        radius_r_next;
  logic [RADIUS_BITS-1:0]        step_c;
  logic [RADIUS_BITS-1:0]        step_c_next;
  logic signed [DEC_W-1:0]       decision;
  logic signed [DEC_W-1:0]       decision_next;
  logic [1:0]                    span_index;
  logic [1:0]                    span_index_next;
  logic [POS_W-1:0]              span_pos;
  logic [POS_W-1:0]              span_pos_next;
  logic [POS_W-1:0]              pos_inc;
  logic [COLOR_BITS-1:0]         held_color;

  logic [RADIUS_BITS-1:0]        half;
  logic [RADIUS_BITS-1:0]        vert;
  logic [SPAN_W-1:0]             px;
  logic [SPAN_W-1:0]             py;
  logic                          in_clip;
  logic                          span_end;
  logic [DEC_W-1:0]              c_ext;
  logic [DEC_W-1:0]              r_ext;
  fcsr_result_t                  res_new;

  fcsr_result_t                  slot [QDEPTH];
  logic [QPTR_W-1:0]             wr_ptr;
  logic [QPTR_W-1:0]             rd_ptr;
  logic [QCNT_W-1:0]             res_count;
  logic                          fire;
  logic                          do_pop;

  assign fire     = cmd_valid && (res_count != QCNT_W'(QDEPTH));
  assign cmd_take = fire;
  assign do_pop   = pop && !empty;
  assign empty    = (res_count == '0);
  assign result   = slot[rd_ptr];

  assign half = span_index[0] ? radius_r : step_c;
  assign vert = span_index[0] ? step_c : radius_r;

  always_comb begin
    px = SPAN_W'(centre_col) - SPAN_W'(half) + SPAN_W'(span_pos);
    if (span_index[1]) begin
      py = SPAN_W'(centre_row) - SPAN_W'(vert);
    end else begin
      py = SPAN_W'(centre_row) + SPAN_W'(vert);
    end
    in_clip = !px[SPAN_W-1] && !py[SPAN_W-1]
           && (px < SPAN_W'(clip.width)) && (py < SPAN_W'(clip.height))
           && (px <= SPAN_W'(COORD_MAX)) && (py <= SPAN_W'(COORD_MAX));
  end

  assign pos_inc  = span_pos + POS_W'(1);
  assign span_end = (pos_inc == {half, 1'b0});
  assign c_ext    = DEC_W'(step_c);
  assign r_ext    = DEC_W'(radius_r);

  always_comb begin
    busy_next       = busy;
    radius_r_next   = radius_r;
    step_c_next     = step_c;
    decision_next   = decision;
    span_index_next = span_index;
    span_pos_next   = span_pos;
    res_new         = '0;
    if (cmd.start) begin
      radius_r_next   = cmd.radius;
      step_c_next     = '0;
      decision_next   = DEC_W'(1) - DEC_W'(cmd.radius);
      // The first narrow span is empty while the count is zero.
      span_index_next = SPAN_WIDE_BOT;
      span_pos_next   = '0;
      busy_next       = (cmd.radius != '0);
      res_new.done_res = (cmd.radius == '0);
    end else begin
      if (busy) begin
        if (!span_end) begin
          span_pos_next = pos_inc;
        end else begin
          span_pos_next = '0;
          priority if (span_index == SPAN_WIDE_TOP) begin
            span_index_next = SPAN_NARROW_BOT;
            if (decision[DEC_W-1]) begin
              decision_next = decision + (c_ext << 1) + DEC_W'(DEC_STEP_IN);
              radius_r_next = radius_r;
            end else begin
              decision_next = decision + ((c_ext - r_ext) << 1) + DEC_W'(DEC_STEP_OUT);
              radius_r_next = radius_r - RADIUS_BITS'(1);
            end
            step_c_next = step_c + RADIUS_BITS'(1);
            busy_next   = (radius_r_next > step_c_next);
          end else if (span_index == SPAN_WIDE_BOT && step_c == '0) begin
            span_index_next = SPAN_WIDE_TOP;
          end else begin
            span_index_next = span_index + 2'd1;
          end
        end
        if (in_clip) begin
          res_new.pixel_x     = px[COORD_BITS-1:0];
          res_new.pixel_y     = py[COORD_BITS-1:0];
          res_new.pixel_color = held_color;
          res_new.write_valid = 1'b1;
        end
      end
      res_new.done_res = !busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      radius_r <= radius_r_next;
      step_c   <= step_c_next;
      decision <= decision_next;
      if (cmd.start) begin
        centre_col <= cmd.center_x;
        centre_row <= cmd.center_y;
        held_color <= cmd.fill_color;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      span_index <= SPAN_NARROW_BOT;
      span_pos   <= '0;
    end else if (fire) begin
      busy       <= busy_next;
      span_index <= span_index_next;
      span_pos   <= span_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      slot[wr_ptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      res_count <= '0;
    end else begin
      if (fire) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({fire, do_pop})
        2'b10:   res_count <= res_count + QCNT_W'(1);
        2'b01:   res_count <= res_count - QCNT_W'(1);
        default: res_count <= res_count;
      endcase
    end
  end

  // While a circle is live the radius stays above the count.
  `FCSR_ASSERT(a_radius_above_count, clk, rst, busy |-> (radius_r > step_c))
  // An empty span is never left pending between commands.
  `FCSR_ASSERT(a_no_empty_span, clk, rst, busy |-> (span_index[0] || step_c != '0))
  // The offset always lies inside the current span.
  `FCSR_ASSERT(a_pos_in_span, clk, rst, busy |-> (span_pos < {half, 1'b0}))
  // The result queue never overfills.
  `FCSR_ASSERT_NEVER(a_res_overflow, clk, rst, res_count > QCNT_W'(QDEPTH))
  // A command taken while the result queue is empty leaves a result there on the next cycle.
  `FCSR_ASSERT(a_fire_fills, clk, rst, (fire && empty) |=> !empty)

endmodule

`default_nettype wire

[sv/filled_circle_span_rasterizer.sv]
// Top level of the filled circle span rasterizer: front queue, span walker, clip registers.
// Depends on fcsr_pkg, fcsr_cfg, fcsr_front and fcsr_back.
//
// A start request loads a circle; each advance request during a fill yields one candidate
// pixel of the fill, with write_valid low for pixels outside the clip window. Every request
// gives exactly one result. The block takes one request per clock and returns one result
// per clock while results are popped and neither queue is full. A request is first
// registered in the two-entry input queue; the span walker, which settles empty spans and
// the midpoint update of a pass in the same cycle as the pixel it emits, then writes the
// result into the result queue, from which it can be popped. Both sides hold two entries,
// so either side may stall without stopping the other at once.
`default_nettype none

module filled_circle_span_rasterizer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  fcsr_pkg::fcsr_item_t             item,
  output logic                             empty,
  input  logic                             pop,
  output fcsr_pkg::fcsr_result_t           result,
  input  logic                             cfg_wen,
  input  logic [fcsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcsr_pkg::CLIP_BITS-1:0]   cfg_wdata
);
  import fcsr_pkg::*;

  fcsr_clip_t clip;
  fcsr_cmd_t  cmd;
  logic       cmd_valid;
  logic       cmd_take;

  fcsr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .clip      (clip)
  );

  fcsr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  fcsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .clip      (clip),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

[tb/sv/filled_circle_span_rasterizer_test.sv]
// Self-checking testbench for filled_circle_span_rasterizer: a directed table, then random
// circle fills under several clip settings, each result checked against table or predictor.
// Depends on fcsr_pkg and the filled_circle_span_rasterizer RTL.
`default_nettype none

module filled_circle_span_rasterizer_test;
  import fcsr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_REQUESTS = 80;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    fcsr_item_t   req;
    logic         typed;
    fcsr_result_t want;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  fcsr_item_t           item = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  fcsr_result_t         result;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CLIP_WIDTH;
  logic [CLIP_BITS-1:0] cfg_wdata = '0;

  // Predictor state, mirroring the block from reset onwards.
  int         clip_w = int'(CLIP_WIDTH_RESET);
  int         clip_h = int'(CLIP_HEIGHT_RESET);
  bit         fill_busy = 1'b0;
  int         ctr_x = 0;
  int         ctr_y = 0;
  int         cur_r = 0;
  int         cur_c = 0;
  int         decision = 0;
  logic [1:0] span_sel = SPAN_NARROW_BOT;
  int         span_off = 0;
  logic [COLOR_BITS-1:0] colour_held = '0;

  fcsr_result_t  expected_pixels[$];
  directed_row_t directed_rows[$];

  int send_gap_pct = 31;
  int pop_gap_pct  = 80;
  int mismatch_count = 0;
  int requests_sent = 0;
  int circles_started = 0;
  int pixels_written = 0;
  int idle_cycles = 0;

  filled_circle_span_rasterizer dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int span_half();
    return span_sel[0] ? cur_r : cur_c;
  endfunction

  // Steps past finished or empty spans; the midpoint update closes each pass.
  function automatic void skip_finished_spans();
    while (fill_busy && span_off >= 2 * span_half()) begin
      span_off = 0;
      if (span_sel == SPAN_WIDE_TOP) begin
        span_sel = SPAN_NARROW_BOT;
        if (decision < 0) begin
          decision += 2 * cur_c + DEC_STEP_IN;
        end else begin
          decision += 2 * (cur_c - cur_r) + DEC_STEP_OUT;
          cur_r--;
        end
        cur_c++;
        fill_busy = cur_r > cur_c;
      end else begin
        span_sel = span_sel + 2'd1;
      end
    end
  endfunction

  function automatic fcsr_result_t rasterize_step(input fcsr_item_t req);
    fcsr_result_t res;
    int x;
    int y;
    res = '0;
    if (req.mode == MODE_START) begin
      ctr_x = req.center_x;
      ctr_y = req.center_y;
      cur_r = req.radius;
      colour_held = req.fill_color;
      cur_c = 0;
      decision = 1 - cur_r;
      span_sel = SPAN_NARROW_BOT;
      span_off = 0;
      fill_busy = cur_r > 0;
      skip_finished_spans();
    end else if (fill_busy) begin
      x = ctr_x - span_half() + span_off;
      case (span_sel)
        SPAN_NARROW_BOT: y = ctr_y + cur_r;
        SPAN_WIDE_BOT:   y = ctr_y + cur_c;
        SPAN_NARROW_TOP: y = ctr_y - cur_r;
        default:         y = ctr_y - cur_c;
      endcase
      if (x >= 0 && y >= 0 && x < clip_w && y < clip_h &&
          x <= COORD_MAX && y <= COORD_MAX) begin
        res.pixel_x = x[COORD_BITS-1:0];
        res.pixel_y = y[COORD_BITS-1:0];
        res.pixel_color = colour_held;
        res.write_valid = 1'b1;
      end
      span_off++;
      skip_finished_spans();
    end
    res.done_res = !fill_busy;
    return res;
  endfunction

  function automatic fcsr_item_t start_req(input int cx, input int cy, input int r,
                                           input int col);
    fcsr_item_t req;
    req.mode = MODE_START;
    req.center_x = cx[COORD_BITS-1:0];
    req.center_y = cy[COORD_BITS-1:0];
    req.radius = r[RADIUS_BITS-1:0];
    req.fill_color = col[COLOR_BITS-1:0];
    return req;
  endfunction

  function automatic fcsr_item_t advance_req(input bit scramble);
    fcsr_item_t req;
    req = scramble ? start_req($urandom, $urandom, $urandom, $urandom) : '0;
    req.mode = MODE_ADVANCE;
    return req;
  endfunction

  function automatic fcsr_result_t no_pixel(input logic done);
    fcsr_result_t res;
    res = '0;
    res.done_res = done;
    return res;
  endfunction

  function automatic void add_row(input fcsr_item_t req, input logic typed,
                                  input fcsr_result_t want);
    directed_row_t row;
    row.req = req;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  task automatic send_request(input fcsr_item_t req, input logic typed,
                              input fcsr_result_t want);
    fcsr_result_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    predicted = rasterize_step(req);
    expected_pixels.push_back(typed ? want : predicted);
    requests_sent++;
    if (req.mode == MODE_START) circles_started++;
    if (predicted.write_valid) pixels_written++;
  endtask

  // Holds requests back until every outstanding result has been taken.
  task automatic wait_for_drain();
    push <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_clips(input int w, input int h);
    cfg_wen <= 1'b1;
    cfg_index <= CFG_CLIP_WIDTH;
    cfg_wdata <= w[CLIP_BITS-1:0];
    @(posedge clk);
    cfg_index <= CFG_CLIP_HEIGHT;
    cfg_wdata <= h[CLIP_BITS-1:0];
    @(posedge clk);
    cfg_wen <= 1'b0;
    clip_w = w;
    clip_h = h;
    @(posedge clk);
  endtask

  // Mostly small circles run to completion; some are abandoned by a fresh start.
  task automatic draw_circle(input int budget_end);
    fcsr_item_t req;
    int reach_x;
    int reach_y;
    int advance_cap;
    int steps;
    reach_x = (clip_w + 8 > COORD_MAX) ? COORD_MAX : clip_w + 8;
    reach_y = (clip_h + 8 > COORD_MAX) ? COORD_MAX : clip_h + 8;
    req = start_req($urandom_range(1) ? $urandom_range(0, reach_x)
                                      : $urandom_range(0, COORD_MAX),
                    $urandom_range(1) ? $urandom_range(0, reach_y)
                                      : $urandom_range(0, COORD_MAX),
                    ($urandom_range(19) == 0) ? $urandom_range(0, 511)
                                              : $urandom_range(0, 7),
                    $urandom_range(0, 65535));
    send_request(req, 1'b0, '0);
    if (req.radius > 16) begin
      advance_cap = $urandom_range(1, 40);
    end else if ($urandom_range(7) == 0) begin
      advance_cap = $urandom_range(0, 12);
    end else begin
      advance_cap = 1 << 20;
    end
    steps = 0;
    while (fill_busy && steps < advance_cap && requests_sent < budget_end) begin
      send_request(advance_req(1'b1), 1'b0, '0);
      steps++;
    end
    repeat ($urandom_range(0, 2)) send_request(advance_req(1'b1), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    fcsr_result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: x=%0d y=%0d colour=%h valid=%b done=%b",
                     result.pixel_x, result.pixel_y, result.pixel_color,
                     result.write_valid, result.done_res);
        end else begin
          want = expected_pixels.pop_front();
          if (result.pixel_x !== want.pixel_x || result.pixel_y !== want.pixel_y ||
              result.pixel_color !== want.pixel_color ||
              result.write_valid !== want.write_valid || result.done_res !== want.done_res) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("mismatch: expected x=%0d y=%0d colour=%h valid=%b done=%b",
                       want.pixel_x, want.pixel_y, want.pixel_color, want.write_valid,
                       want.done_res);
              $display("          got      x=%0d y=%0d colour=%h valid=%b done=%b",
                       result.pixel_x, result.pixel_y, result.pixel_color,
                       result.write_valid, result.done_res);
            end
          end
        end
      end
      pop <= ($urandom_range(99) >= pop_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("filled_circle_span_rasterizer_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int phase_start;
    add_row(advance_req(1'b0), 1'b1, no_pixel(1'b1));
    add_row(start_req(0, 0, 0, 16'hFFFF), 1'b1, no_pixel(1'b1));
    add_row(advance_req(1'b0), 1'b1, no_pixel(1'b1));
    add_row(start_req(0, 0, 1, 16'hFFFF), 1'b1, no_pixel(1'b0));
    repeat (4) add_row(advance_req(1'b0), 1'b0, '0);
    add_row(advance_req(1'b0), 1'b1, no_pixel(1'b1));
    add_row(start_req(1023, 1023, 511, 16'h0000), 1'b1, no_pixel(1'b0));
    repeat (4) add_row(advance_req(1'b0), 1'b0, '0);
    add_row(start_req(319, 239, 2, 16'hA5A5), 1'b1, no_pixel(1'b0));
    repeat (8) add_row(advance_req(1'b0), 1'b0, '0);
    add_row(start_req(512, 512, 511, 16'hFFFF), 1'b1, no_pixel(1'b0));
    add_row(advance_req(1'b0), 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    wait_for_drain();

    for (phase = 0; phase < 6; phase++) begin
      send_gap_pct = (phase < 2) ? 31 : (phase < 4) ? 80 : 0;
      pop_gap_pct  = (phase < 2) ? 80 : (phase < 4) ? 31 : 0;
      case (phase)
        0: write_clips(1024, 1024);
        1: write_clips(1, 1);
        2: write_clips(0, 0);
        3: write_clips(2047, 2047);
        4: write_clips($urandom_range(0, 2047), $urandom_range(0, 2047));
        default: write_clips(320, 240);
      endcase
      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_REQUESTS)
        draw_circle(phase_start + PHASE_REQUESTS);
      wait_for_drain();
    end

    $display("Ran %0d requests, %0d of them circle starts, with %0d pixels inside the window,",
             requests_sent, circles_started, pixels_written);
    $display("over six clip settings from zero to full width and three idling patterns.");
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("filled_circle_span_rasterizer_test: PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatch_count, expected_pixels.size());
      $display("filled_circle_span_rasterizer_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
